// ----- rtl/tssa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the two-stacks-in-one-array block
// no dependencies

package tssa_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_CLEAR = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } result_type;

   localparam int CAP_W   = 9;
   localparam int COUNT_W = 9;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic read_needed;
   } dp_status_type;

endpackage

// ----- rtl/tssa_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine: handshakes and step sequencing
// depends on tssa_pkg

module tssa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tssa_pkg::dp_status_type dp_status,
   output tssa_pkg::ctrl_type      ctrl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && ready_ff) begin
                  state_ff <= S_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (dp_status.read_needed) begin
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_RESP;
                  valid_ff <= 1'b1;
               end
            end
            S_READ: begin
               state_ff <= S_RESP;
               valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_tready) begin
                  state_ff <= S_IDLE;
                  valid_ff <= 1'b0;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready  = ready_ff && !reset;
   assign rsp_tvalid  = valid_ff;
   assign ctrl.accept = req_tvalid && req_tready;
   assign ctrl.exec   = (state_ff == S_EXEC);
   assign ctrl.load   = (state_ff == S_READ);

endmodule

// ----- rtl/tssa_datapath.sv -----
`timescale 1ns / 1ps
// datapath: entry store, fill counters, capacity register, result register
// depends on tssa_pkg

module tssa_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tssa_pkg::ctrl_type              ctrl,
   output tssa_pkg::dp_status_type         dp_status,
   input  logic [1:0]                      in_command,
   input  logic                            in_stack_sel,
   input  logic signed [31:0]              in_value_int,
   input  logic [7:0]                      in_value_char,
   input  logic                            csr_wr_en,
   input  logic [tssa_pkg::CAP_W-1:0]      csr_wr_data,
   output logic [1:0]                      out_status,
   output logic signed [31:0]              out_int,
   output logic [7:0]                      out_char,
   output logic [tssa_pkg::COUNT_W-1:0]    out_total
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > tssa_pkg::CAP_W) ? FW : tssa_pkg::CAP_W;
   localparam int SW = ((FW + 1) > tssa_pkg::COUNT_W) ? (FW + 1) : tssa_pkg::COUNT_W;

   logic [39:0] mem [DEPTH];

   tssa_pkg::command_type     cmd_ff;
   logic                      sel_ff;
   logic [31:0]               vint_ff;
   logic [7:0]                vchar_ff;
   logic [FW-1:0]             fill_low_ff, fill_low_in;
   logic [FW-1:0]             fill_high_ff, fill_high_in;
   logic [tssa_pkg::CAP_W-1:0] cap_ff;
   logic [39:0]               rd_data_ff;
   tssa_pkg::result_type      status_ff, status_in;
   logic [31:0]               out_int_ff;
   logic [7:0]                out_char_ff;
   logic [tssa_pkg::COUNT_W-1:0] total_ff;

   logic [CW-1:0] cap_wide;
   logic [FW-1:0] eff_cap;
   logic [SW-1:0] sum_now, sum_in;
   logic          full;
   logic          sel_empty;
   logic          wr_en;
   logic          rd_en;
   logic [FW-1:0] wr_idx_full, rd_idx_full;

   // clamp capacity to 1..DEPTH
   always_comb begin
      cap_wide = CW'(cap_ff);
      if (cap_wide == '0) begin
         eff_cap = FW'(1);
      end else if (cap_wide > CW'(DEPTH)) begin
         eff_cap = FW'(DEPTH);
      end else begin
         eff_cap = cap_wide[FW-1:0];
      end
   end

   assign sum_now   = SW'(fill_low_ff) + SW'(fill_high_ff);
   assign full      = (sum_now >= SW'(eff_cap));
   assign sel_empty = sel_ff ? (fill_high_ff == '0) : (fill_low_ff == '0);
   assign wr_idx_full = sel_ff ? (eff_cap - fill_high_ff - FW'(1)) : fill_low_ff;
   assign rd_idx_full = sel_ff ? (eff_cap - fill_high_ff) : (fill_low_ff - FW'(1));

   always_comb begin
      fill_low_in  = fill_low_ff;
      fill_high_in = fill_high_ff;
      status_in    = tssa_pkg::ST_OK;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (cmd_ff)
         tssa_pkg::CMD_PUSH: begin
            if (full) begin
               status_in = tssa_pkg::ST_FULL;
            end else begin
               wr_en = 1'b1;
               if (sel_ff) begin
                  fill_high_in = fill_high_ff + FW'(1);
               end else begin
                  fill_low_in = fill_low_ff + FW'(1);
               end
            end
         end
         tssa_pkg::CMD_POP, tssa_pkg::CMD_PEEK: begin
            if (sel_empty) begin
               status_in = tssa_pkg::ST_EMPTY;
            end else begin
               rd_en = 1'b1;
               if (cmd_ff == tssa_pkg::CMD_POP) begin
                  if (sel_ff) begin
                     fill_high_in = fill_high_ff - FW'(1);
                  end else begin
                     fill_low_in = fill_low_ff - FW'(1);
                  end
               end
            end
         end
         tssa_pkg::CMD_CLEAR: begin
            if (sel_ff) begin
               fill_high_in = '0;
            end else begin
               fill_low_in = '0;
            end
         end
         default: begin
            status_in = tssa_pkg::ST_OK;
         end
      endcase
   end

   assign sum_in = SW'(fill_low_in) + SW'(fill_high_in);
   assign dp_status.read_needed = rd_en;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_low_ff  <= '0;
         fill_high_ff <= '0;
         cap_ff       <= tssa_pkg::CAP_RESET;
      end else begin
         if (ctrl.exec) begin
            fill_low_ff  <= fill_low_in;
            fill_high_ff <= fill_high_in;
         end
         if (csr_wr_en && (fill_low_ff == '0) && (fill_high_ff == '0)) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff   <= tssa_pkg::command_type'(in_command);
         sel_ff   <= in_stack_sel;
         vint_ff  <= in_value_int;
         vchar_ff <= in_value_char;
      end
      if (ctrl.exec) begin
         status_ff   <= status_in;
         out_int_ff  <= '0;
         out_char_ff <= '0;
         total_ff    <= sum_in[tssa_pkg::COUNT_W-1:0];
      end
      if (ctrl.load) begin
         out_int_ff  <= rd_data_ff[31:0];
         out_char_ff <= rd_data_ff[39:32];
      end
   end

   // entry store
   always_ff @(posedge clock) begin
      if (ctrl.exec && wr_en) begin
         mem[wr_idx_full[AW-1:0]] <= {vchar_ff, vint_ff};
      end
      if (ctrl.exec && rd_en) begin
         rd_data_ff <= mem[rd_idx_full[AW-1:0]];
      end
   end

   assign out_status = status_ff;
   assign out_int    = out_int_ff;
   assign out_char   = out_char_ff;
   assign out_total  = total_ff;

endmodule

// ----- rtl/two_stacks_shared_array.sv -----
`timescale 1ns / 1ps
// two stacks in one store: push, pop, peek and clear on either stack
// rsp_tvalid is registered: it rises on leaving S_EXEC for push, clear and
// refused commands, and on leaving S_READ for pop and peek, set by the registered store read
// a new command word is not accepted until the previous result word has been taken
// reset: synchronous, clears both fills and sets capacity to 256; the store is not cleared

module two_stacks_shared_array #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command[1:0], value_int[33:2], value_char[41:34]
   input  logic        req_tuser,   // stack_sel[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status[1:0], out_int[33:2], out_char[41:34], total_count[50:42]
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   tssa_pkg::ctrl_type      ctrl;
   tssa_pkg::dp_status_type dp_status;

   logic [1:0]  out_status;
   logic [31:0] out_int;
   logic [7:0]  out_char;
   logic [8:0]  out_total;

   tssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .ctrl       (ctrl)
   );

   tssa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .dp_status     (dp_status),
      .in_command    (req_tdata[1:0]),
      .in_stack_sel  (req_tuser),
      .in_value_int  (req_tdata[33:2]),
      .in_value_char (req_tdata[41:34]),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .out_status    (out_status),
      .out_int       (out_int),
      .out_char      (out_char),
      .out_total     (out_total)
   );

   assign rsp_tdata = {5'd0, out_total, out_char, out_int, out_status};

endmodule

// ----- tb/stack_checker.sv -----
`timescale 1ns / 1ps
// checker for two_stacks_shared_array: watches the command, result and csr channels,
// keeps its own copy of both stacks and the capacity, and compares every result word
// depends on tssa_pkg

module stack_checker #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output int          error_count,
   output int          words_pending,
   output int          results_checked,
   output int          full_seen,
   output int          empty_seen
);

   localparam int AW = $clog2(DEPTH);

   typedef struct packed {
      tssa_pkg::result_type         status;
      logic [31:0]                  out_int;
      logic [7:0]                   out_char;
      logic [tssa_pkg::COUNT_W-1:0] total_count;
   } stack_reply_type;

   logic [39:0]                slot_mem [DEPTH];
   int unsigned                low_fill;
   int unsigned                high_fill;
   logic [tssa_pkg::CAP_W-1:0] cap_reg;
   stack_reply_type            awaited_replies [$];

   function automatic int unsigned usable_slots();
      if (cap_reg == 0) begin
         return 1;
      end
      if (cap_reg > DEPTH) begin
         return DEPTH;
      end
      return 32'(cap_reg);
   endfunction

   function automatic stack_reply_type run_stack_command(tssa_pkg::command_type cmd,
         logic sel, logic [31:0] vi, logic [7:0] vc);
      stack_reply_type r;
      int unsigned slots;
      int unsigned fill;
      int unsigned slot;
      slots = usable_slots();
      fill = sel ? high_fill : low_fill;
      r = '0;
      r.status = tssa_pkg::ST_OK;
      case (cmd)
         tssa_pkg::CMD_PUSH: begin
            if (low_fill + high_fill >= slots) begin
               r.status = tssa_pkg::ST_FULL;
            end else if (!sel) begin
               slot_mem[AW'(low_fill)] = {vc, vi};
               low_fill++;
            end else begin
               high_fill++;
               slot_mem[AW'(slots - high_fill)] = {vc, vi};
            end
         end
         tssa_pkg::CMD_POP, tssa_pkg::CMD_PEEK: begin
            if (fill == 0) begin
               r.status = tssa_pkg::ST_EMPTY;
            end else begin
               slot = sel ? slots - high_fill : low_fill - 1;
               {r.out_char, r.out_int} = slot_mem[AW'(slot)];
               if (cmd == tssa_pkg::CMD_POP) begin
                  if (sel) high_fill--;
                  else low_fill--;
               end
            end
         end
         default: begin
            if (sel) high_fill = 0;
            else low_fill = 0;
         end
      endcase
      r.total_count = tssa_pkg::COUNT_W'(low_fill + high_fill);
      return r;
   endfunction

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count < 50) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      stack_reply_type want;
      stack_reply_type got;
      if (reset) begin
         low_fill = 0;
         high_fill = 0;
         cap_reg = tssa_pkg::CAP_RESET;
         awaited_replies.delete();
         error_count = 0;
         results_checked = 0;
         full_seen = 0;
         empty_seen = 0;
      end else begin
         if (csr_wr_en && low_fill == 0 && high_fill == 0) begin
            cap_reg = csr_wr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = tssa_pkg::result_type'(rsp_tdata[1:0]);
            got.out_int = rsp_tdata[33:2];
            got.out_char = rsp_tdata[41:34];
            got.total_count = rsp_tdata[50:42];
            if (awaited_replies.size() == 0) begin
               error_count++;
               if (error_count < 50) begin
                  $display("%0t: result word with nothing expected, actual %h", $time, rsp_tdata);
               end
            end else begin
               want = awaited_replies.pop_front();
               report_field("status", 32'(want.status), 32'(got.status));
               report_field("out_int", want.out_int, got.out_int);
               report_field("out_char", 32'(want.out_char), 32'(got.out_char));
               report_field("total_count", 32'(want.total_count), 32'(got.total_count));
               results_checked++;
               if (want.status == tssa_pkg::ST_FULL) full_seen++;
               if (want.status == tssa_pkg::ST_EMPTY) empty_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_replies.push_back(run_stack_command(
               tssa_pkg::command_type'(req_tdata[1:0]),
               req_tuser, req_tdata[33:2], req_tdata[41:34]));
         end
      end
      words_pending = awaited_replies.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// top of the two_stacks_shared_array bench: clock, reset, command stimulus, result
// back-pressure and capacity writes; checking is done by stack_checker
// depends on tssa_pkg, two_stacks_shared_array and stack_checker

module testbench;

   localparam int NUM_PHASES = 9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // command[1:0], value_int[33:2], value_char[41:34]
   logic        req_tuser = 1'b0; // stack_sel[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // status[1:0], out_int[33:2], out_char[41:34], total_count[50:42]
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;

   int error_count;
   int words_pending;
   int results_checked;
   int full_seen;
   int empty_seen;

   int gap_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int words_sent = 0;
   int capacity_writes = 0;

   int phase_cap   [NUM_PHASES] = '{0, 1, 256, 3, 511, 8, 300, 2, 17};
   int phase_items [NUM_PHASES] = '{120, 120, 420, 150, 200, 150, 150, 100, 120};
   int phase_push  [NUM_PHASES] = '{50, 50, 90, 50, 60, 55, 45, 50, 55};
   int phase_clear [NUM_PHASES] = '{5, 5, 0, 5, 2, 5, 3, 5, 4};
   int phase_gap   [NUM_PHASES] = '{0, 51, 0, 0, 10, 51, 0, 10, 0};
   int phase_stall [NUM_PHASES] = '{0, 0, 51, 0, 10, 0, 51, 10, 0};

   two_stacks_shared_array #(
      .DEPTH(256)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stack_checker #(
      .DEPTH(256)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .words_pending   (words_pending),
      .results_checked (results_checked),
      .full_seen       (full_seen),
      .empty_seen      (empty_seen)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d result words outstanding", words_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(tssa_pkg::command_type cmd, logic sel, logic [31:0] vi,
         logic [7:0] vc);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {6'd0, vc, vi, cmd};
      req_tuser <= sel;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic random_word(int push_pct, int clear_pct);
      int r;
      tssa_pkg::command_type cmd;
      r = $urandom_range(99);
      if (r < push_pct) cmd = tssa_pkg::CMD_PUSH;
      else if (r < push_pct + clear_pct) cmd = tssa_pkg::CMD_CLEAR;
      else if ($urandom_range(1)) cmd = tssa_pkg::CMD_POP;
      else cmd = tssa_pkg::CMD_PEEK;
      send_word(cmd, 1'($urandom_range(1)), $urandom(), 8'($urandom_range(255)));
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_capacity(logic [8:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_writes++;
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset capacity, empty stacks, field extremes
      send_word(tssa_pkg::CMD_POP, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_PEEK, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_PUSH, 1'b0, 32'h8000_0000, 8'h00);
      send_word(tssa_pkg::CMD_PUSH, 1'b0, 32'h7fff_ffff, 8'hff);
      send_word(tssa_pkg::CMD_PUSH, 1'b1, 32'h0000_0000, 8'h80);
      send_word(tssa_pkg::CMD_PUSH, 1'b1, 32'hffff_ffff, 8'h7f);
      send_word(tssa_pkg::CMD_PEEK, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_PEEK, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_CLEAR, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_PEEK, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_CLEAR, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_CLEAR, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_PUSH, 1'b0, 32'h5555_5555, 8'haa);
      settle();
      // not empty, so this write must be dropped
      set_capacity(9'd4);
      send_word(tssa_pkg::CMD_PEEK, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_CLEAR, 1'b0, 32'h0, 8'h00);
      settle();
      // tiny store: full on both sides
      set_capacity(9'd2);
      send_word(tssa_pkg::CMD_PUSH, 1'b0, 32'haaaa_aaaa, 8'h55);
      send_word(tssa_pkg::CMD_PUSH, 1'b1, 32'h0000_0001, 8'h01);
      send_word(tssa_pkg::CMD_PUSH, 1'b0, 32'h1234_5678, 8'h9a);
      send_word(tssa_pkg::CMD_PUSH, 1'b1, 32'h8765_4321, 8'hbc);
      send_word(tssa_pkg::CMD_PEEK, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b1, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b0, 32'h0, 8'h00);
      send_word(tssa_pkg::CMD_POP, 1'b1, 32'h0, 8'h00);

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_word(tssa_pkg::CMD_CLEAR, 1'b0, $urandom(), 8'($urandom_range(255)));
         send_word(tssa_pkg::CMD_CLEAR, 1'b1, $urandom(), 8'($urandom_range(255)));
         settle();
         set_capacity(9'(phase_cap[p]));
         gap_pct = phase_gap[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < phase_items[p]; n++) begin
            // long result hold-off while commands keep coming
            if (p == 3 && n == 20) hold_request = 1'b1;
            random_word(phase_push[p], phase_clear[p]);
         end
      end
      gap_pct = 0;
      stall_pct = 0;
      settle();

      $display("sent %0d command words over %0d capacity writes, %0d results checked",
         words_sent, capacity_writes, results_checked);
      $display("refused as full %0d times, as empty %0d times", full_seen, empty_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tssa_pkg.sv
rtl/tssa_ctrl.sv
rtl/tssa_datapath.sv
rtl/two_stacks_shared_array.sv
tb/stack_checker.sv
tb/testbench.sv
